@@ rtl/sopr_pkg.sv @@
// Shared widths, register codes and the factorial weight table for the ordinal pattern ranker.
package sopr_pkg;

	localparam int LEN_W   = 4;
	localparam int CNT_W   = 4;
	localparam int IDX_W   = 22;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;

	localparam logic [LEN_W-1:0] LEN_RESET = 4'd3;
	localparam logic [LEN_W-1:0] LEN_MIN   = 4'd2;

	// register index, taken from paddr above the byte offset
	localparam logic REG_PATTERN_LENGTH = 1'b0;

	typedef struct packed {
		logic load;
		logic clear;
	} cell_ctl_t;

	function automatic logic [IDX_W-1:0] fact(input int p);
		logic [IDX_W-1:0] f;
		case (p)
			0:       f = 22'd1;
			1:       f = 22'd1;
			2:       f = 22'd2;
			3:       f = 22'd6;
			4:       f = 22'd24;
			5:       f = 22'd120;
			6:       f = 22'd720;
			7:       f = 22'd5040;
			8:       f = 22'd40320;
			9:       f = 22'd362880;
			default: f = 22'd0;
		endcase
		return f;
	endfunction

endpackage

@@ rtl/sopr_cell.sv @@
// One window cell: holds a sample and the count of newer samples that are smaller.
module sopr_cell #(
	parameter int POS         = 0,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sopr_pkg::cell_ctl_t          ctl,
	input  logic [SAMPLE_BITS-1:0]       sample,
	input  logic [SAMPLE_BITS-1:0]       prev_val,
	input  logic [sopr_pkg::CNT_W-1:0]   prev_cnt,
	input  logic [sopr_pkg::LEN_W-1:0]   eff_len,
	output logic [SAMPLE_BITS-1:0]       val,
	output logic [sopr_pkg::CNT_W-1:0]   cnt,
	output logic [sopr_pkg::IDX_W-1:0]   term
);

	logic [SAMPLE_BITS-1:0]     val_q;
	logic [sopr_pkg::CNT_W-1:0] cnt_q;

	// the incoming sample is newer than the one passing through: count it if smaller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			cnt_q <= '0;
		end else if (ctl.load) begin
			if (ctl.clear && (POS != 0)) begin
				val_q <= '0;
				cnt_q <= '0;
			end else begin
				val_q <= prev_val;
				cnt_q <= prev_cnt + sopr_pkg::CNT_W'(sample < prev_val);
			end
		end
	end

	assign val  = val_q;
	assign cnt  = cnt_q;
	assign term = (sopr_pkg::LEN_W'(POS) < eff_len)
		? sopr_pkg::IDX_W'(cnt_q) * sopr_pkg::fact(POS) : '0;

endmodule

@@ rtl/sopr_apb.sv @@
// Configuration register port: pattern length register and its clamped effective value.
module sopr_apb #(
	parameter int MAX_LEN = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sopr_pkg::PADDR_W-1:0]  paddr,
	input  logic [sopr_pkg::DATA_W-1:0]   pwdata,
	output logic [sopr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [sopr_pkg::LEN_W-1:0]    eff_len
);

	logic [sopr_pkg::LEN_W-1:0] len_q;
	logic                       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[sopr_pkg::PADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= sopr_pkg::LEN_RESET;
		end else if (psel && penable && pwrite && pready
			&& (reg_idx == sopr_pkg::REG_PATTERN_LENGTH)) begin
			len_q <= pwdata[sopr_pkg::LEN_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			sopr_pkg::REG_PATTERN_LENGTH: prdata = sopr_pkg::DATA_W'(len_q);
			default:                      prdata = '0;
		endcase
	end

	// clamp to the supported range
	always_comb begin
		if (len_q < sopr_pkg::LEN_MIN) begin
			eff_len = sopr_pkg::LEN_MIN;
		end else if (len_q > sopr_pkg::LEN_W'(MAX_LEN)) begin
			eff_len = sopr_pkg::LEN_W'(MAX_LEN);
		end else begin
			eff_len = len_q;
		end
	end

endmodule

@@ rtl/sliding_ordinal_pattern_rank.sv @@
// Top level: sliding window ordinal pattern ranker with cell chain and sum pipeline.
//
// Input channel: sample and restart, transferred when in_valid is high and
// in_stall is low. Output channel: pattern_index and pattern_valid, transferred
// when out_valid is high and out_stall is low. One result per input sample.
// pattern_length is written over the APB port at byte address 0.
//
// Throughput is one sample per cycle while the receiver does not stall. The
// window is a chain of MAX_LEN cells that shift on every transfer; each cell
// keeps a running count of newer, smaller samples, so the rank is a weighted
// sum of the cell counts. A result moves from the cells, which update on the
// accepting edge, through a pair-sum stage to the output register.
// Reset clears the window, the fill count and all pipeline valids, and sets
// pattern_length to 3. When the receiver stalls the output register holds;
// the stages behind it keep filling bubbles, and in_stall rises only once the
// cells hold a result that cannot move forward. restart empties the window and
// the sample of that transfer becomes its first entry.
module sliding_ordinal_pattern_rank #(
	parameter int MAX_LEN     = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sopr_pkg::IDX_W-1:0]    pattern_index,
	output logic                          pattern_valid,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sopr_pkg::PADDR_W-1:0]  paddr,
	input  logic [sopr_pkg::DATA_W-1:0]   pwdata,
	output logic [sopr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int NPAIR = (MAX_LEN + 1) / 2;

	logic [sopr_pkg::LEN_W-1:0] eff_len;
	sopr_pkg::cell_ctl_t        ctl;

	logic [SAMPLE_BITS-1:0]     val     [MAX_LEN];
	logic [SAMPLE_BITS-1:0]     prv_val [MAX_LEN];
	logic [sopr_pkg::CNT_W-1:0] cnt     [MAX_LEN];
	logic [sopr_pkg::CNT_W-1:0] prv_cnt [MAX_LEN];
	logic [sopr_pkg::IDX_W-1:0] term    [MAX_LEN];

	logic [sopr_pkg::LEN_W-1:0] fill_q;
	logic [sopr_pkg::LEN_W-1:0] fill_base;
	logic                       vld_q;

	logic [sopr_pkg::IDX_W-1:0] psum_d  [NPAIR];
	logic [sopr_pkg::IDX_W-1:0] psum_s1 [NPAIR];
	logic                       pv_s1;
	logic                       vld_s1;
	logic [sopr_pkg::IDX_W-1:0] total;
	logic [sopr_pkg::IDX_W-1:0] idx_s2;
	logic                       pv_s2;
	logic                       vld_s2;

	logic out_go;
	logic s1_go;
	logic load1;
	logic load2;
	logic accept;

	sopr_apb #(
		.MAX_LEN (MAX_LEN)
	) u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.eff_len (eff_len)
	);

	// pipeline flow: a stage moves when the one ahead is empty or moving
	assign out_go   = !vld_s2 || !out_stall;
	assign s1_go    = !vld_s1 || out_go;
	assign load2    = vld_s1 && out_go;
	assign load1    = vld_q && s1_go;
	assign in_stall = vld_q && !s1_go;
	assign accept   = in_valid && !in_stall;

	assign ctl.load  = accept;
	assign ctl.clear = restart;

	for (genvar p = 0; p < MAX_LEN; p++) begin : g_cell
		if (p == 0) begin : g_head
			assign prv_val[p] = sample;
			assign prv_cnt[p] = '0;
		end else begin : g_link
			assign prv_val[p] = val[p-1];
			assign prv_cnt[p] = cnt[p-1];
		end

		sopr_cell #(
			.POS         (p),
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sample   (sample),
			.prev_val (prv_val[p]),
			.prev_cnt (prv_cnt[p]),
			.eff_len  (eff_len),
			.val      (val[p]),
			.cnt      (cnt[p]),
			.term     (term[p])
		);
	end

	assign fill_base = restart ? '0 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= (fill_base < sopr_pkg::LEN_W'(MAX_LEN))
					? fill_base + sopr_pkg::LEN_W'(1) : fill_base;
			end
			if (accept) begin
				vld_q <= 1'b1;
			end else if (load1) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NPAIR; i++) begin
			psum_d[i] = term[2*i];
			if (2*i + 1 < MAX_LEN) begin
				psum_d[i] = term[2*i] + term[2*i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_go) begin
			vld_s1 <= vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			psum_s1 <= psum_d;
			pv_s1   <= (fill_q >= eff_len);
		end
	end

	always_comb begin
		total = '0;
		for (int i = 0; i < NPAIR; i++) begin
			total = total + psum_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_go) begin
			vld_s2 <= vld_s1;
		end
	end

	// drop the rank while the window is short
	always_ff @(posedge clk) begin
		if (load2) begin
			idx_s2 <= pv_s1 ? total : '0;
			pv_s2  <= pv_s1;
		end
	end

	assign out_valid     = vld_s2;
	assign pattern_index = idx_s2;
	assign pattern_valid = pv_s2;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= sopr_pkg::LEN_W'(MAX_LEN))
		else $error("fill count above window depth");

	a_restart_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart |=> fill_q == sopr_pkg::LEN_W'(1))
		else $error("restart did not leave exactly one sample");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !restart && (fill_q < sopr_pkg::LEN_W'(MAX_LEN))
		|=> fill_q == $past(fill_q) + sopr_pkg::LEN_W'(1))
		else $error("fill count did not advance on transfer");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pattern_valid |-> pattern_index == '0)
		else $error("nonzero rank for a short window");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !out_go |=> vld_s1)
		else $error("pair-sum stage lost a result under stall");

endmodule

@@ sim/tb.sv @@
// Testbench for the sliding ordinal pattern ranker: directed and random streams.
module tb;

	localparam int WIN_DEPTH     = 10;
	localparam int SMP_W         = 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam logic [sopr_pkg::PADDR_W-1:0] ADDR_LENGTH =
		{sopr_pkg::REG_PATTERN_LENGTH, 2'b00};
	localparam logic [sopr_pkg::PADDR_W-1:0] ADDR_UNMAPPED = ADDR_LENGTH + 3'd4;

	typedef struct packed {
		logic [sopr_pkg::IDX_W-1:0] index;
		logic                       valid;
	} rank_t;

	typedef enum int {
		STYLE_NOISE, STYLE_TIES, STYLE_RISE, STYLE_FALL, STYLE_EXTREME
	} seq_style_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [SMP_W-1:0]                sample;
	logic                            restart;
	logic                            out_valid;
	logic                            out_stall;
	logic [sopr_pkg::IDX_W-1:0]      pattern_index;
	logic                            pattern_valid;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [sopr_pkg::PADDR_W-1:0]    paddr;
	logic [sopr_pkg::DATA_W-1:0]     pwdata;
	logic [sopr_pkg::DATA_W-1:0]     prdata;
	logic                            pready;

	// predictor state
	logic [SMP_W-1:0]                win_model [WIN_DEPTH];
	int                              fill_model = 0;
	logic [sopr_pkg::LEN_W-1:0]      length_reg = sopr_pkg::LEN_RESET;

	rank_t                pending_ranks [$];
	int                   err_count = 0;
	int                   send_gap_pct = 0;
	int                   recv_stall_pct = 0;
	int                   hold_cycles = 0;

	sliding_ordinal_pattern_rank uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int factorial(input int n);
		int f;
		f = 1;
		for (int i = 2; i <= n; i++)
			f = f * i;
		return f;
	endfunction

	// shift the sample in and rank the newest k samples, oldest first
	function automatic rank_t predict_rank(input logic [SMP_W-1:0] s, input logic rs);
		int k;
		int cnt;
		rank_t r;
		logic [sopr_pkg::IDX_W-1:0] acc;
		k = int'(length_reg);
		if (k < 2) k = 2;
		if (k > WIN_DEPTH) k = WIN_DEPTH;
		if (rs) begin
			for (int i = 0; i < WIN_DEPTH; i++)
				win_model[i] = '0;
			fill_model = 0;
		end
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			win_model[i] = win_model[i-1];
		win_model[0] = s;
		if (fill_model < WIN_DEPTH) fill_model++;
		acc = '0;
		r.valid = (fill_model >= k);
		if (r.valid) begin
			for (int a = 0; a < k; a++) begin
				cnt = 0;
				// ties: the earlier sample counts as smaller, so only strict less
				for (int b = a + 1; b < k; b++)
					if (win_model[k-1-b] < win_model[k-1-a]) cnt++;
				acc += sopr_pkg::IDX_W'(cnt * factorial(k - 1 - a));
			end
		end
		r.index = acc;
		return r;
	endfunction

	function automatic logic [SMP_W-1:0] next_sample(input seq_style_t st,
			input logic [SMP_W-1:0] prev);
		if ($urandom_range(9) == 0) return SMP_W'($urandom);
		case (st)
			STYLE_TIES:    return SMP_W'($urandom_range(3));
			STYLE_RISE:    return SMP_W'(prev + $urandom_range(1, 500));
			STYLE_FALL:    return SMP_W'(prev - $urandom_range(1, 500));
			STYLE_EXTREME: return $urandom_range(1) ? '1 : '0;
			default:       return SMP_W'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// enter and leave at a falling edge
	task automatic send_sample(input logic [SMP_W-1:0] s, input logic rs);
		while ($urandom_range(99) < send_gap_pct) @(negedge clk);
		in_valid = 1'b1;
		sample   = s;
		restart  = rs;
		do @(posedge clk); while (in_stall);
		pending_ranks.push_back(predict_rank(s, rs));
		@(negedge clk);
		in_valid = 1'b0;
		restart  = 1'b0;
	endtask

	task automatic write_reg(input logic [sopr_pkg::PADDR_W-1:0] addr,
			input logic [sopr_pkg::DATA_W-1:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[sopr_pkg::PADDR_W-1:2] == sopr_pkg::REG_PATTERN_LENGTH)
			length_reg = data[sopr_pkg::LEN_W-1:0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_ranks.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		rank_t exp_r;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_ranks.size() == 0) begin
				report_mismatch($sformatf("unexpected result index=%0d valid=%0b",
					pattern_index, pattern_valid));
			end else begin
				exp_r = pending_ranks.pop_front();
				if (pattern_index !== exp_r.index)
					report_mismatch($sformatf("pattern_index got %0d want %0d",
						pattern_index, exp_r.index));
				if (pattern_valid !== exp_r.valid)
					report_mismatch($sformatf("pattern_valid got %0b want %0b",
						pattern_valid, exp_r.valid));
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			hold_cycles--;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic test_default_length();
		send_sample(16'd0, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'd1, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0001, 1'b0);
	endtask

	task automatic test_length_extremes();
		wait_idle();
		write_reg(ADDR_LENGTH, 32'd10);
		// strictly falling run gives the top rank
		for (int i = 0; i < 10; i++)
			send_sample(SMP_W'(32'hFFFF - i * 7000), i == 0);
		wait_idle();
		write_reg(ADDR_LENGTH, 32'd2);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b0);
		wait_idle();
		write_reg(ADDR_LENGTH, 32'd0);
		send_sample(16'h1234, 1'b0);
		wait_idle();
		write_reg(ADDR_LENGTH, 32'hFFFF_FFFF);
		send_sample(16'h0F0F, 1'b0);
		wait_idle();
		// unmapped register: length must stay as it was
		write_reg(ADDR_UNMAPPED, 32'd5);
		send_sample(16'hF0F0, 1'b0);
		send_sample(16'h0000, 1'b0);
	endtask

	task automatic test_random_stream(input int n_items);
		int sent;
		int seg_len;
		seq_style_t style;
		logic [SMP_W-1:0] cur;
		logic [sopr_pkg::DATA_W-1:0] wdata;
		sent = 0;
		cur = SMP_W'($urandom);
		while (sent < n_items) begin
			wait_idle();
			wdata = $urandom;
			wdata[sopr_pkg::LEN_W-1:0] = ($urandom_range(9) < 7)
				? sopr_pkg::LEN_W'($urandom_range(2, 10))
				: sopr_pkg::LEN_W'($urandom_range(15));
			write_reg(($urandom_range(15) == 0) ? ADDR_UNMAPPED : ADDR_LENGTH, wdata);
			seg_len = $urandom_range(20, 60);
			style = seq_style_t'($urandom_range(4));
			repeat (seg_len) begin
				cur = next_sample(style, cur);
				send_sample(cur, $urandom_range(49) == 0);
			end
			sent += seg_len;
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		write_reg(ADDR_LENGTH, 32'd10);
		hold_cycles = HOLD_CYCLES;
		repeat (40)
			send_sample(SMP_W'($urandom), 1'b0);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		sample    = '0;
		restart   = 1'b0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		for (int i = 0; i < WIN_DEPTH; i++)
			win_model[i] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_gap_pct   = 26;
		recv_stall_pct = 78;
		test_default_length();
		test_length_extremes();
		test_random_stream(500);

		send_gap_pct   = 78;
		recv_stall_pct = 26;
		test_random_stream(500);

		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_random_stream(500);
		test_backpressure();

		while (pending_ranks.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/sopr_pkg.sv
rtl/sopr_cell.sv
rtl/sopr_apb.sv
rtl/sliding_ordinal_pattern_rank.sv
sim/tb.sv
